### hdl/gvt_pkg.sv
// Shared types and constants of the grid voxel traversal block.
package gvt_pkg;

  // Field widths fixed by the interface
  localparam int COORD_W   = 4;
  localparam int SIGNS_W   = 6;
  localparam int TIME_W    = 32;
  localparam int KIND_W    = 2;
  localparam int FACE_W    = 2;
  localparam int CFG_W     = 5;
  localparam int REG_IDX_W = 2;
  localparam int AXIS_W    = 2;
  localparam int STEP_W    = 2;

  // Result budget per ray, counted items
  localparam int MAX_RESULTS = 48;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // Grid size after reset
  localparam int CELLS_RESET = 16;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_CELL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LIMIT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GRID  = 2'd2;

  // Entered face codes
  localparam logic [FACE_W-1:0] FACE_X     = 2'd0;
  localparam logic [FACE_W-1:0] FACE_Y     = 2'd1;
  localparam logic [FACE_W-1:0] FACE_Z     = 2'd2;
  localparam logic [FACE_W-1:0] FACE_START = 2'd3;

  // Per-axis step codes
  localparam logic [STEP_W-1:0] STEP_PLUS  = 2'd1;
  localparam logic [STEP_W-1:0] STEP_MINUS = 2'd2;

  // Axis numbers
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_CELLS_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_Z = 2'd2;

  typedef struct packed {
    logic [3*COORD_W-1:0] start_cell;
    logic [SIGNS_W-1:0]   step_signs;
    logic [TIME_W-1:0]    t_start;
    logic [TIME_W-1:0]    next_x;
    logic [TIME_W-1:0]    next_y;
    logic [TIME_W-1:0]    next_z;
    logic [TIME_W-1:0]    delta_x;
    logic [TIME_W-1:0]    delta_y;
    logic [TIME_W-1:0]    delta_z;
    logic [TIME_W-1:0]    t_limit;
  } ray_t;

  typedef struct packed {
    logic [KIND_W-1:0]  item_kind;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
    logic [TIME_W-1:0]  entry_t;
    logic [FACE_W-1:0]  face_axis;
    logic               last;
  } item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_outside;
    logic step_last;
    logic out_free;
  } status_t;

endpackage

### hdl/gvt_ifs.sv
// Channel interfaces of the grid voxel traversal block.
interface gvt_ray_if;
  import gvt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [3*COORD_W-1:0] start_cell;
  logic [SIGNS_W-1:0]   step_signs;
  logic [TIME_W-1:0]    t_start;
  logic [TIME_W-1:0]    next_x;
  logic [TIME_W-1:0]    next_y;
  logic [TIME_W-1:0]    next_z;
  logic [TIME_W-1:0]    delta_x;
  logic [TIME_W-1:0]    delta_y;
  logic [TIME_W-1:0]    delta_z;
  logic [TIME_W-1:0]    t_limit;

  modport source (
    output valid, start_cell, step_signs, t_start, next_x, next_y, next_z,
           delta_x, delta_y, delta_z, t_limit,
    input  ready
  );
  modport sink (
    input  valid, start_cell, step_signs, t_start, next_x, next_y, next_z,
           delta_x, delta_y, delta_z, t_limit,
    output ready
  );
endinterface

interface gvt_item_if;
  import gvt_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  item_kind;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;
  logic [COORD_W-1:0] cell_z;
  logic [TIME_W-1:0]  entry_t;
  logic [FACE_W-1:0]  face_axis;
  logic               last;

  modport source (
    output valid, item_kind, cell_x, cell_y, cell_z, entry_t, face_axis, last,
    input  ready
  );
  modport sink (
    input  valid, item_kind, cell_x, cell_y, cell_z, entry_t, face_axis, last,
    output ready
  );
endinterface

interface gvt_cfg_if;
  import gvt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/gvt_ctrl.sv
// Walk controller: sequences load, start item and step items of one ray.
module gvt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             ray_valid,
  output logic             ray_ready,
  input  gvt_pkg::status_t status,
  output gvt_pkg::cmd_t    cmd
);
  import gvt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_START = 3'b010,
    S_WALK  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Take a ray only between walks
  assign ray_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (ray_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (status.out_free) begin
          cmd.start = 1'b1;
          state_next = status.start_outside ? S_IDLE : S_WALK;
        end
      end
      S_WALK: begin
        if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.step_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/gvt_datapath.sv
// Walk datapath: grid size, ray state, step unit and result register.
module gvt_datapath #(
  parameter int LIM_MAX = 16,
  parameter int T_BITS  = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  gvt_pkg::cmd_t                   cmd,
  output gvt_pkg::status_t                status,
  input  logic                            cfg_we,
  input  logic [gvt_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [gvt_pkg::CFG_W-1:0]       cfg_data,
  input  gvt_pkg::ray_t                   ray,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gvt_pkg::item_t                  out_item
);
  import gvt_pkg::*;

  // Wide enough for the grid limit and for any start coordinate
  localparam int CW_LIM = $clog2(LIM_MAX + 1);
  localparam int CW = (CW_LIM > COORD_W) ? CW_LIM : COORD_W;
  localparam int LIM_RESET = (LIM_MAX < CELLS_RESET) ? LIM_MAX : CELLS_RESET;
  localparam logic [T_BITS-1:0] T_INF = '1;

  // Map a register value onto 1..LIM_MAX
  function automatic logic [CW-1:0] clamp_cells(input logic [CFG_W-1:0] v);
    logic [CW-1:0] r;
    begin
      if (v == '0) begin
        r = CW'(1);
      end else if (32'(v) > LIM_MAX) begin
        r = CW'(LIM_MAX);
      end else begin
        r = CW'(v);
      end
      return r;
    end
  endfunction

  logic [CW-1:0]     lim      [3];
  logic [CW-1:0]     cur      [3];
  logic [STEP_W-1:0] signs    [3];
  logic [T_BITS-1:0] bound    [3];
  logic [T_BITS-1:0] delta    [3];
  logic [T_BITS-1:0] t_cur;
  logic [T_BITS-1:0] t_limit;
  logic              outside;
  logic [CNT_W-1:0]  count;

  logic [COORD_W-1:0] start_coord [3];
  logic               start_out;
  logic               lt10, lt20, lt21;
  logic [AXIS_W-1:0]  best;
  logic [T_BITS-1:0]  b_best;
  logic [T_BITS-1:0]  d_best;
  logic [T_BITS:0]    b_sum;
  logic [T_BITS-1:0]  b_sat;
  logic [CW-1:0]      cur_best;
  logic [CW-1:0]      cur_new;
  logic [CW-1:0]      cur_stepped [3];
  logic [STEP_W-1:0]  sign_best;
  logic [CW-1:0]      lim_best;
  logic               leave;
  logic               end_limit;

  // Unpack start cell and test it against the grid
  assign start_coord[0] = ray.start_cell[COORD_W-1:0];
  assign start_coord[1] = ray.start_cell[2*COORD_W-1:COORD_W];
  assign start_coord[2] = ray.start_cell[3*COORD_W-1:2*COORD_W];
  assign start_out = (6'(start_coord[0]) >= 6'(lim[0])) ||
                     (6'(start_coord[1]) >= 6'(lim[1])) ||
                     (6'(start_coord[2]) >= 6'(lim[2]));

  // Pick the earliest boundary, lowest axis on ties
  assign lt10 = bound[1] < bound[0];
  assign lt20 = bound[2] < bound[0];
  assign lt21 = bound[2] < bound[1];
  assign best = lt10 ? (lt21 ? AXIS_Z : AXIS_Y) : (lt20 ? AXIS_Z : AXIS_X);

  assign b_best    = bound[best];
  assign d_best    = delta[best];
  assign cur_best  = cur[best];
  assign sign_best = signs[best];
  assign lim_best  = lim[best];

  // Saturating boundary advance
  assign b_sum = {1'b0, b_best} + {1'b0, d_best};
  assign b_sat = b_sum[T_BITS] ? T_INF : b_sum[T_BITS-1:0];

  // Step the chosen axis and check the grid edge
  always_comb begin
    cur_new = cur_best;
    leave   = 1'b0;
    if (sign_best == STEP_PLUS) begin
      cur_new = cur_best + CW'(1);
      leave   = ((6'(cur_best) + 6'd1) >= 6'(lim_best));
    end else if (sign_best == STEP_MINUS) begin
      cur_new = cur_best - CW'(1);
      leave   = (cur_best == '0);
    end
    for (int a = 0; a < 3; a++) begin
      cur_stepped[a] = (AXIS_W'(a) == best) ? cur_new : cur[a];
    end
  end

  // Budget spent, t past the limit, or no finite boundary left
  assign end_limit = (count >= CNT_W'(MAX_RESULTS - 1)) || (t_cur > t_limit) ||
                     (b_best == T_INF);

  assign status.start_outside = outside;
  assign status.step_last     = end_limit || leave;
  assign status.out_free      = !out_valid || out_ready;

  // Grid size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        lim[a] <= CW'(LIM_RESET);
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELLS_X: lim[0] <= clamp_cells(cfg_data);
        REG_CELLS_Y: lim[1] <= clamp_cells(cfg_data);
        REG_CELLS_Z: lim[2] <= clamp_cells(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Ray state: load, then advance one boundary per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = 0; a < 3; a++) begin
        cur[a] <= CW'(start_coord[a]);
        signs[a] <= ray.step_signs[2*a +: STEP_W];
      end
      bound[0] <= T_BITS'(ray.next_x);
      bound[1] <= T_BITS'(ray.next_y);
      bound[2] <= T_BITS'(ray.next_z);
      delta[0] <= T_BITS'(ray.delta_x);
      delta[1] <= T_BITS'(ray.delta_y);
      delta[2] <= T_BITS'(ray.delta_z);
      t_cur    <= T_BITS'(ray.t_start);
      t_limit  <= T_BITS'(ray.t_limit);
      outside  <= start_out;
    end else if (cmd.start) begin
      count <= CNT_W'(1);
    end else if (cmd.step && !end_limit) begin
      t_cur <= b_best;
      bound[best] <= b_sat;
      if (!leave) begin
        cur[best] <= cur_new;
        count <= count + CNT_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.start || cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      out_item.item_kind <= outside ? KIND_GRID : KIND_CELL;
      out_item.cell_x    <= COORD_W'(cur[0]);
      out_item.cell_y    <= COORD_W'(cur[1]);
      out_item.cell_z    <= COORD_W'(cur[2]);
      out_item.entry_t   <= TIME_W'(t_cur);
      out_item.face_axis <= outside ? FACE_X : FACE_START;
      out_item.last      <= outside;
    end else if (cmd.step) begin
      if (end_limit) begin
        out_item.item_kind <= KIND_LIMIT;
        out_item.cell_x    <= COORD_W'(cur[0]);
        out_item.cell_y    <= COORD_W'(cur[1]);
        out_item.cell_z    <= COORD_W'(cur[2]);
        out_item.entry_t   <= TIME_W'(t_cur);
        out_item.face_axis <= FACE_X;
        out_item.last      <= 1'b1;
      end else if (leave) begin
        out_item.item_kind <= KIND_GRID;
        out_item.cell_x    <= COORD_W'(cur[0]);
        out_item.cell_y    <= COORD_W'(cur[1]);
        out_item.cell_z    <= COORD_W'(cur[2]);
        out_item.entry_t   <= TIME_W'(b_best);
        out_item.face_axis <= FACE_X;
        out_item.last      <= 1'b1;
      end else begin
        out_item.item_kind <= KIND_CELL;
        out_item.cell_x    <= COORD_W'(cur_stepped[0]);
        out_item.cell_y    <= COORD_W'(cur_stepped[1]);
        out_item.cell_z    <= COORD_W'(cur_stepped[2]);
        out_item.entry_t   <= TIME_W'(b_best);
        out_item.face_axis <= FACE_W'(best);
        out_item.last      <= 1'b0;
      end
    end
  end

endmodule

### hdl/grid_voxel_traversal_core.sv
// Top level of the grid voxel traversal block: 3D DDA walk of one ray at a time.
//
//  channel | dir | transfer when        | carries
//  --------+-----+----------------------+-------------------------------------
//  ray     | in  | ray.valid & ray.ready| prepared ray (start cell, times)
//  item    | out | item.valid&item.ready| visited cell or end item
//  cfg     | in  | cfg.valid & cfg.ready| grid size register write, always ready
//
// A ray is first loaded from the ray channel; each of its result items then
// comes from the single step unit (earliest-boundary pick, saturating add,
// edge test). A ray gives at most 48 result items, its last one included.
// Reset (rst, synchronous) sets the grid to 16 cells per axis, clipped to
// GRID_MAX, and empties the result register. A stall on item holds the walk;
// the next ray is taken while the last result of the previous one waits.
module grid_voxel_traversal_core #(
  parameter int GRID_MAX = 16,
  parameter int T_BITS   = 32
) (
  input logic       clk,
  input logic       rst,
  gvt_ray_if.sink   ray,
  gvt_item_if.source item,
  gvt_cfg_if.sink   cfg
);
  import gvt_pkg::*;

  // Grid sizes above the register range cannot occur
  localparam int LIM_MAX = (GRID_MAX < 31) ? GRID_MAX : 31;

  cmd_t    cmd;
  status_t status;
  ray_t    ray_data;
  item_t   out_item;
  logic    out_valid;

  // Gather the ray payload
  assign ray_data.start_cell = ray.start_cell;
  assign ray_data.step_signs = ray.step_signs;
  assign ray_data.t_start    = ray.t_start;
  assign ray_data.next_x     = ray.next_x;
  assign ray_data.next_y     = ray.next_y;
  assign ray_data.next_z     = ray.next_z;
  assign ray_data.delta_x    = ray.delta_x;
  assign ray_data.delta_y    = ray.delta_y;
  assign ray_data.delta_z    = ray.delta_z;
  assign ray_data.t_limit    = ray.t_limit;

  assign cfg.ready = 1'b1;

  gvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .ray_valid (ray.valid),
    .ray_ready (ray.ready),
    .status    (status),
    .cmd       (cmd)
  );

  gvt_datapath #(
    .LIM_MAX (LIM_MAX),
    .T_BITS  (T_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .ray       (ray_data),
    .out_valid (out_valid),
    .out_ready (item.ready),
    .out_item  (out_item)
  );

  // Drive the result channel
  assign item.valid     = out_valid;
  assign item.item_kind = out_item.item_kind;
  assign item.cell_x    = out_item.cell_x;
  assign item.cell_y    = out_item.cell_y;
  assign item.cell_z    = out_item.cell_z;
  assign item.entry_t   = out_item.entry_t;
  assign item.face_axis = out_item.face_axis;
  assign item.last      = out_item.last;

endmodule

### hdl/gvt_checker.sv
// Port checker of the grid voxel traversal block and its bind.
module gvt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          ray_valid,
  input logic                          ray_ready,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic [gvt_pkg::KIND_W-1:0]    item_kind,
  input logic [gvt_pkg::TIME_W-1:0]    entry_t,
  input logic [gvt_pkg::FACE_W-1:0]    face_axis,
  input logic                          last
);
  import gvt_pkg::*;

  // Hold a stalled result
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(entry_t) &&
      $stable(item_kind) && $stable(last))
    else $error("result changed while stalled");

  // Close the run with an end item only
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> (last == (item_kind != KIND_CELL)))
    else $error("last flag does not match item kind");

  // Report end items with face x
  a_end_face: assert property (@(posedge clk) disable iff (rst)
    item_valid && last |-> face_axis == FACE_X)
    else $error("end item with non-x face");

  // Show the start face only on a visited cell
  a_start_face: assert property (@(posedge clk) disable iff (rst)
    item_valid && face_axis == FACE_START |-> item_kind == KIND_CELL && !last)
    else $error("start face on an end item");

  // Drop ready once a ray has been taken
  a_one_ray: assert property (@(posedge clk) disable iff (rst)
    ray_valid && ray_ready |=> !ray_ready)
    else $error("second ray taken during a walk");

endmodule

bind grid_voxel_traversal_core gvt_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .ray_valid  (ray.valid),
  .ray_ready  (ray.ready),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .item_kind  (item.item_kind),
  .entry_t    (item.entry_t),
  .face_axis  (item.face_axis),
  .last       (item.last)
);
